// File: rtl/swsfd_pkg.sv
// Shared types and constants for the single-wire sensor frame decoder.
package swsfd_pkg;

    localparam int unsigned FRAME_LEN       = 40;
    localparam int unsigned BIT_IDX_W       = 6;
    localparam int unsigned INTERVAL_W      = 14;
    localparam int unsigned THRESH_W        = 8;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd47;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x.
    localparam logic [15:0] RECIP_10    = 16'd52429;
    localparam int unsigned RECIP_SHIFT = 19;

    localparam int unsigned MID_DEPTH_DEF = 4;
    localparam int unsigned OUT_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_SENSOR_LOW  = 3'd1,
        PH_SENSOR_HIGH = 3'd2,
        PH_BIT_LOW     = 3'd3,
        PH_BIT_HIGH    = 3'd4,
        PH_ENDED       = 3'd5
    } phase_t;

    localparam logic KIND_EDGE    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // Work handed from the front to the back for one request.
    typedef struct packed {
        logic                 frame;
        logic [FRAME_LEN-1:0] bits;
    } op_t;

    typedef struct packed {
        logic       frame_done;
        logic       checksum_ok;
        logic [7:0] temperature_div10;
        logic [7:0] humidity_div10;
    } result_t;

endpackage

// File: rtl/swsfd_queue.sv
// Small register-based FIFO used between the front, the back and the result ports.
module swsfd_queue #(
    parameter int unsigned DEPTH = 4,
    parameter int unsigned WIDTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign count = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> (!full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("queue count out of range");

endmodule

// File: rtl/swsfd_front.sv
// Front end: edge-driven phase machine that collects frame bits and issues one op per request.
module swsfd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [swsfd_pkg::THRESH_W-1:0]      cfg_wdata,
    input  logic                                accept,
    input  logic                                kind,
    input  logic [swsfd_pkg::INTERVAL_W-1:0]    interval_us,
    input  logic                                line_level,
    output swsfd_pkg::op_t                      op
);

    import swsfd_pkg::*;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(FRAME_LEN - 1);

    phase_t                phase_reg, phase_next;
    logic [BIT_IDX_W-1:0]  bit_index_reg, bit_index_next;
    logic [FRAME_LEN-1:0]  frame_bits_reg, frame_bits_next;
    logic [THRESH_W-1:0]   threshold_reg;
    logic [BIT_IDX_W-1:0]  bit_pos;
    logic                  bit_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    // The first received bit lands in the most significant position.
    assign bit_pos = LAST_BIT - bit_index_reg;
    assign bit_val = (interval_us >= {{(INTERVAL_W-THRESH_W){1'b0}}, threshold_reg});

    always_comb
    begin
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        frame_bits_next = frame_bits_reg;
        op.frame        = 1'b0;
        op.bits         = frame_bits_reg;
        if (kind == KIND_RESTART)
        begin
            phase_next = PH_IDLE;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (!line_level)
                    begin
                        phase_next = PH_SENSOR_LOW;
                    end
                end
                PH_SENSOR_LOW:  phase_next = PH_SENSOR_HIGH;
                PH_SENSOR_HIGH: phase_next = PH_BIT_LOW;
                PH_BIT_LOW:     phase_next = PH_BIT_HIGH;
                PH_BIT_HIGH:
                begin
                    frame_bits_next[bit_pos] = bit_val;
                    op.bits = frame_bits_next;
                    if (bit_index_reg == LAST_BIT)
                    begin
                        bit_index_next = '0;
                        phase_next     = PH_ENDED;
                        op.frame       = 1'b1;
                    end
                    else
                    begin
                        bit_index_next = bit_index_reg + BIT_IDX_W'(1);
                        phase_next     = PH_BIT_LOW;
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_index_reg  <= '0;
            frame_bits_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            frame_bits_reg <= frame_bits_next;
        end
    end

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= LAST_BIT)
        else $error("bit index past end of frame");
    a_frame_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op.frame) |=> (phase_reg == PH_ENDED && bit_index_reg == '0))
        else $error("frame op issued without ending the frame");
    a_ended_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_ENDED && kind == KIND_EDGE) |=> phase_reg == PH_ENDED)
        else $error("edge left the ended phase");

endmodule

// File: rtl/swsfd_back.sv
// Back end: checks and scales completed frames and forms one result per op.
module swsfd_back #(
    parameter int unsigned OUT_DEPTH = swsfd_pkg::OUT_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           op_avail,
    input  swsfd_pkg::op_t                 op,
    output logic                           op_take,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                           res_push,
    output swsfd_pkg::result_t             res
);

    import swsfd_pkg::*;

    localparam int unsigned OCW = $clog2(OUT_DEPTH + 1);
    localparam logic [OCW:0] OUT_LIMIT = (OCW+1)'(OUT_DEPTH);

    logic        s1_valid_reg;
    logic        s1_frame_reg;
    logic        s1_ok_reg;
    logic [31:0] s1_hum_prod_reg;
    logic [31:0] s1_tmp_prod_reg;
    logic [7:0]  last_temperature_reg, last_temperature_next;
    logic [7:0]  last_humidity_reg, last_humidity_next;
    logic [OCW:0] inflight;
    logic [7:0]  byte_sum;
    logic [15:0] hum_word;
    logic [15:0] tmp_word;

    // Only take an op when the result queue is sure to have room for it.
    assign inflight = {1'b0, out_count} + {{OCW{1'b0}}, s1_valid_reg};
    assign op_take  = op_avail && (inflight < OUT_LIMIT);

    assign hum_word = op.bits[39:24];
    assign tmp_word = op.bits[23:8];
    assign byte_sum = op.bits[39:32] + op.bits[31:24] + op.bits[23:16] + op.bits[15:8];

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            s1_frame_reg    <= op.frame;
            s1_ok_reg       <= (byte_sum == op.bits[7:0]);
            s1_hum_prod_reg <= hum_word * RECIP_10;
            s1_tmp_prod_reg <= tmp_word * RECIP_10;
        end
    end

    always_comb
    begin
        last_temperature_next = last_temperature_reg;
        last_humidity_next    = last_humidity_reg;
        if (s1_valid_reg && s1_frame_reg)
        begin
            if (s1_ok_reg)
            begin
                last_temperature_next = s1_tmp_prod_reg[RECIP_SHIFT+7:RECIP_SHIFT];
                last_humidity_next    = s1_hum_prod_reg[RECIP_SHIFT+7:RECIP_SHIFT];
            end
            else
            begin
                last_temperature_next = '0;
                last_humidity_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg         <= 1'b0;
            last_temperature_reg <= '0;
            last_humidity_reg    <= '0;
        end
        else
        begin
            s1_valid_reg         <= op_take;
            last_temperature_reg <= last_temperature_next;
            last_humidity_reg    <= last_humidity_next;
        end
    end

    assign res_push              = s1_valid_reg;
    assign res.frame_done        = s1_frame_reg;
    assign res.checksum_ok       = s1_frame_reg && s1_ok_reg;
    assign res.temperature_div10 = last_temperature_next;
    assign res.humidity_div10    = last_humidity_next;

    a_room_for_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ({1'b0, out_count} < OUT_LIMIT))
        else $error("result produced with no room in result queue");
    a_fail_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.frame_done && !res.checksum_ok) |=>
        (last_temperature_reg == '0 && last_humidity_reg == '0))
        else $error("failed frame did not clear stored values");
    a_plain_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !res.frame_done) |=> $stable(last_humidity_reg))
        else $error("stored humidity changed without a frame");

endmodule

// File: rtl/single_wire_sensor_frame_decoder_top.sv
// Top level of the single-wire sensor frame decoder.
//
//  Channel   Direction  Handshake            Payload
//  input     in         push / full          kind, interval_us, line_level
//  result    out        empty / pop          frame_done, checksum_ok,
//                                            temperature_div10, humidity_div10
//  config    in         cfg_we (no stall)    cfg_wdata = bit threshold
//
// One request is accepted per clock while the op queue has room; each yields one result.
// An accepted request passes through the op queue, the back's stage-1 registers and the result queue.
// The front phase machine steps once per accepted request; the back takes one op per clock
// while the result queue has room, so a stalled pop backs up into full.
// Reset clears phase, bit count, frame bits and stored readings, and sets the threshold to 47.
module single_wire_sensor_frame_decoder_top #(
    parameter int unsigned MID_DEPTH = swsfd_pkg::MID_DEPTH_DEF,
    parameter int unsigned OUT_DEPTH = swsfd_pkg::OUT_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [swsfd_pkg::THRESH_W-1:0]   cfg_wdata,
    input  logic                             push,
    output logic                             full,
    input  logic                             kind,
    input  logic [swsfd_pkg::INTERVAL_W-1:0] interval_us,
    input  logic                             line_level,
    output logic                             empty,
    input  logic                             pop,
    output logic                             frame_done,
    output logic                             checksum_ok,
    output logic [7:0]                       temperature_div10,
    output logic [7:0]                       humidity_div10
);

    import swsfd_pkg::*;

    logic    accept;
    op_t     front_op;
    op_t     back_op;
    logic    mid_full;
    logic    mid_empty;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    logic    op_take;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
    logic    res_push;
    result_t res_in;
    result_t res_out;
    logic    out_full;
    logic    out_empty;
    logic    out_pop;

    assign accept  = push && !mid_full;
    assign full    = mid_full;
    assign out_pop = pop && !out_empty;

    swsfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .kind        (kind),
        .interval_us (interval_us),
        .line_level  (line_level),
        .op          (front_op)
    );

    swsfd_queue #(
        .DEPTH (MID_DEPTH),
        .WIDTH ($bits(op_t))
    ) u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (front_op),
        .pop   (op_take),
        .rdata (back_op),
        .full  (mid_full),
        .empty (mid_empty),
        .count (mid_count)
    );

    swsfd_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_avail  (!mid_empty),
        .op        (back_op),
        .op_take   (op_take),
        .out_count (out_count),
        .res_push  (res_push),
        .res       (res_in)
    );

    swsfd_queue #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(result_t))
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .pop   (out_pop),
        .rdata (res_out),
        .full  (out_full),
        .empty (out_empty),
        .count (out_count)
    );

    assign empty             = out_empty;
    assign frame_done        = res_out.frame_done;
    assign checksum_ok       = res_out.checksum_ok;
    assign temperature_div10 = res_out.temperature_div10;
    assign humidity_div10    = res_out.humidity_div10;

    a_op_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mid_count <= ($clog2(MID_DEPTH+1))'(MID_DEPTH))
        else $error("op queue count out of range");
    a_res_never_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !out_full)
        else $error("result pushed into full result queue");
    a_take_needs_op: assert property (@(posedge clk) disable iff (!rst_n)
        op_take |-> !mid_empty)
        else $error("back took an op from an empty queue");

endmodule
